/* rtl/dns_query_fixed_answer_responder_macros.svh */
// ---------------------------------------------------------------------------
// dns responder assertion macros
// shared concurrent assertion forms, clocked on clock, quiet during reset
// ---------------------------------------------------------------------------
`ifndef DNS_QUERY_FIXED_ANSWER_RESPONDER_MACROS_SVH
`define DNS_QUERY_FIXED_ANSWER_RESPONDER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DQFAR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DQFAR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/dqfar_pkg.sv */
// ---------------------------------------------------------------------------
// dqfar_pkg
// types, constants and helpers of the fixed-answer dns responder
// ---------------------------------------------------------------------------
package dqfar_pkg;

   // sizing
   localparam int DEF_MAX_PACKET_BYTES = 512;
   localparam int QUEUE_DEPTH          = 4;
   localparam int ANSWER_LEN           = 16;
   localparam int BURST_W              = $clog2(ANSWER_LEN + 1);
   localparam int TAIL_BYTES           = 4;

   // header byte positions
   localparam int HDR_FLAGS_HI_POS   = 2;
   localparam int HDR_FLAGS_LO_POS   = 3;
   localparam int HDR_ANCOUNT_HI_POS = 6;
   localparam int HDR_ANCOUNT_LO_POS = 7;
   localparam int HDR_NSCOUNT_HI_POS = 8;
   localparam int HDR_ARCOUNT_LO_POS = 11;

   // fixed byte values
   localparam logic [7:0] FLAGS_HI   = 8'h81;
   localparam logic [7:0] FLAGS_LO   = 8'h80;
   localparam logic [7:0] ANCOUNT_LO = 8'h01;
   localparam logic [7:0] ZERO_BYTE  = 8'h00;
   localparam logic [7:0] PTR_HI     = 8'hC0;
   localparam logic [7:0] PTR_LO     = 8'h0C;
   localparam logic [15:0] TYPE_A    = 16'h0001;
   localparam logic [15:0] CLASS_IN  = 16'h0001;
   localparam logic [15:0] RDLENGTH  = 16'h0004;

   // register indexes
   localparam logic CSR_ADDRESS = 1'b0;
   localparam logic CSR_TTL     = 1'b1;
   localparam logic [31:0] TTL_RESET = 32'd120;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_NAME,
      PH_TAIL,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      CMD_BYTE,
      CMD_ABORT,
      CMD_ANSWER
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   typedef struct packed {
      logic [31:0] address;
      logic [31:0] ttl;
   } csr_type;

   // answer byte k of the burst, k from 1 to ANSWER_LEN
   function automatic logic [7:0] answer_byte(input logic [BURST_W-1:0] idx,
                                              input csr_type csr);
      logic [8*ANSWER_LEN-1:0] rec;
      logic [3:0]              sel;
      rec = {PTR_HI, PTR_LO, TYPE_A, CLASS_IN, csr.ttl, RDLENGTH, csr.address};
      sel = 4'(BURST_W'(ANSWER_LEN) - idx);
      return rec[{sel, 3'b000} +: 8];
   endfunction

endpackage

/* rtl/dqfar_req_if.sv */
// ---------------------------------------------------------------------------
// dqfar_req_if
// query byte channel with valid / ready handshake
// ---------------------------------------------------------------------------
interface dqfar_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] query_byte;
   logic       query_last;

   modport source (output valid, output query_byte, output query_last, input ready);
   modport sink   (input valid, input query_byte, input query_last, output ready);
endinterface

/* rtl/dqfar_rsp_if.sv */
// ---------------------------------------------------------------------------
// dqfar_rsp_if
// reply byte channel with valid / ready handshake
// ---------------------------------------------------------------------------
interface dqfar_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] reply_byte;
   logic       reply_last;
   logic       reply_abort;

   modport source (output valid, output reply_byte, output reply_last,
                   output reply_abort, input ready);
   modport sink   (input valid, input reply_byte, input reply_last,
                   input reply_abort, output ready);
endinterface

/* rtl/dqfar_front.sv */
// ---------------------------------------------------------------------------
// dqfar_front
// parses query bytes and turns each one not skipped into a command for the output side
// ---------------------------------------------------------------------------
module dqfar_front
   import dqfar_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
) (
   input  logic         clock,
   input  logic         reset,
   dqfar_req_if.sink    req_chan,
   output cmd_type      push_cmd,
   output logic         push_valid,
   input  logic         push_ready
);

   localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [2:0]       tail_ff, tail_in;

   logic       accept;
   logic       oversize;
   logic       header_end;
   logic       done;
   logic [7:0] ob;

   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && push_ready;

   // classification of the current item
   always_comb begin
      oversize   = pos_ff >= POS_W'(MAX_PACKET_BYTES);
      header_end = pos_ff >= POS_W'(HDR_ARCOUNT_LO_POS);
      done       = (phase_ff == PH_TAIL) && (tail_ff >= 3'(TAIL_BYTES - 1));
      ob         = req_chan.query_byte;
      if (phase_ff == PH_HEADER) begin
         if (pos_ff == POS_W'(HDR_FLAGS_HI_POS)) begin
            ob = FLAGS_HI;
         end else if (pos_ff == POS_W'(HDR_FLAGS_LO_POS)) begin
            ob = FLAGS_LO;
         end else if (pos_ff == POS_W'(HDR_ANCOUNT_HI_POS)) begin
            ob = ZERO_BYTE;
         end else if (pos_ff == POS_W'(HDR_ANCOUNT_LO_POS)) begin
            ob = ANCOUNT_LO;
         end else if (pos_ff >= POS_W'(HDR_NSCOUNT_HI_POS) &&
                      pos_ff <= POS_W'(HDR_ARCOUNT_LO_POS)) begin
            ob = ZERO_BYTE;
         end
      end
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      tail_in  = tail_ff;
      if (accept) begin
         if (phase_ff == PH_SKIP) begin
            if (req_chan.query_last) begin
               phase_in = PH_HEADER;
               pos_in   = '0;
               tail_in  = '0;
            end
         end else if (oversize || done) begin
            phase_in = req_chan.query_last ? PH_HEADER : PH_SKIP;
            pos_in   = '0;
            tail_in  = '0;
         end else if (req_chan.query_last) begin
            phase_in = PH_HEADER;
            pos_in   = '0;
            tail_in  = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            unique case (phase_ff)
               PH_HEADER: begin
                  if (header_end) phase_in = PH_NAME;
               end
               PH_NAME: begin
                  if (req_chan.query_byte == ZERO_BYTE) begin
                     phase_in = PH_TAIL;
                     tail_in  = '0;
                  end
               end
               PH_TAIL: begin
                  tail_in = tail_ff + 3'd1;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // command towards the queue
   always_comb begin
      push_valid    = accept && (phase_ff != PH_SKIP);
      push_cmd.kind = CMD_BYTE;
      push_cmd.data = ob;
      if (oversize) begin
         push_cmd.kind = CMD_ABORT;
         push_cmd.data = ZERO_BYTE;
      end else if (done) begin
         push_cmd.kind = CMD_ANSWER;
      end else if (req_chan.query_last) begin
         push_cmd.kind = CMD_ABORT;
         push_cmd.data = ZERO_BYTE;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         tail_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         tail_ff  <= tail_in;
      end
   end

endmodule

/* rtl/dqfar_fifo.sv */
// ---------------------------------------------------------------------------
// dqfar_fifo
// short command queue between the parser and the output side
// ---------------------------------------------------------------------------
module dqfar_fifo
   import dqfar_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type push_cmd,
   input  logic    push_valid,
   output logic    push_ready,
   output cmd_type pop_cmd,
   output logic    pop_valid,
   input  logic    pop_ready
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          mem [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/dqfar_back.sv */
// ---------------------------------------------------------------------------
// dqfar_back
// carries out queued commands: single bytes, aborts and the answer burst
// ---------------------------------------------------------------------------
module dqfar_back
   import dqfar_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  csr_type   csr,
   input  cmd_type   pop_cmd,
   input  logic      pop_valid,
   output logic      pop_ready,
   dqfar_rsp_if.source rsp_chan
);

   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic               out_last_ff, out_last_in;
   logic               out_abort_ff, out_abort_in;
   logic [BURST_W-1:0] burst_ff, burst_in;

   logic load_ok;
   logic bursting;
   logic burst_end;

   assign load_ok   = !out_valid_ff || rsp_chan.ready;
   assign bursting  = burst_ff != '0;
   assign burst_end = burst_ff == BURST_W'(ANSWER_LEN);
   assign pop_ready = load_ok && !bursting;

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.reply_byte  = out_byte_ff;
   assign rsp_chan.reply_last  = out_last_ff;
   assign rsp_chan.reply_abort = out_abort_ff;

   // output stage load
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_abort_in = out_abort_ff;
      burst_in     = burst_ff;
      if (load_ok) begin
         out_valid_in = 1'b0;
         if (bursting) begin
            out_valid_in = 1'b1;
            out_byte_in  = answer_byte(burst_ff, csr);
            out_last_in  = burst_end;
            out_abort_in = 1'b0;
            burst_in     = burst_end ? '0 : burst_ff + BURST_W'(1);
         end else if (pop_valid) begin
            out_valid_in = 1'b1;
            out_byte_in  = pop_cmd.data;
            out_last_in  = pop_cmd.kind == CMD_ABORT;
            out_abort_in = pop_cmd.kind == CMD_ABORT;
            if (pop_cmd.kind == CMD_ANSWER) begin
               burst_in = BURST_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_abort_ff <= out_abort_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         burst_ff     <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         burst_ff     <= burst_in;
      end
   end

endmodule

/* rtl/dns_query_fixed_answer_responder.sv */
// ---------------------------------------------------------------------------
// dns_query_fixed_answer_responder
// streams a dns query in and a fixed-answer a-record response out
// ---------------------------------------------------------------------------
// One query byte is taken per cycle while the command queue (QUEUE_ENTRIES
// entries) has room. Each byte yields at most one command; the last class
// byte of the question yields the 17-byte tail of the reply (that byte plus
// the 16-byte answer), which the output stage sends at one byte per cycle
// while the reply channel is ready. A copied byte passes through the command
// queue and then the output register. Header rewriting, name copy, early-end
// and oversize aborts follow the parser in the front stage; the address and
// ttl registers are read when the answer bytes are sent. There is no
// clearing pass after reset.
`include "dns_query_fixed_answer_responder_macros.svh"

module dns_query_fixed_answer_responder
   import dqfar_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES,
   parameter int QUEUE_ENTRIES    = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   dqfar_req_if.sink   req_chan,
   dqfar_rsp_if.source rsp_chan,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   csr_type csr_ff, csr_in;
   cmd_type push_cmd, pop_cmd;
   logic    push_valid, push_ready;
   logic    pop_valid, pop_ready;

   // configuration registers
   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ADDRESS: csr_in.address = csr_wdata;
            CSR_TTL:     csr_in.ttl     = csr_wdata;
            default:     csr_in         = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.address <= '0;
         csr_ff.ttl     <= TTL_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // parser
   dqfar_front #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   // command queue
   dqfar_fifo #(
      .DEPTH (QUEUE_ENTRIES)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_cmd    (pop_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   // output side
   dqfar_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .pop_cmd   (pop_cmd),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

   // checks
   `DQFAR_ASSERT_SAME(a_abort_shape, rsp_chan.valid && rsp_chan.reply_abort, rsp_chan.reply_last && rsp_chan.reply_byte == ZERO_BYTE, "abort item must be last with a zero byte")
   `DQFAR_ASSERT_SAME(a_answer_tail, rsp_chan.valid && rsp_chan.reply_last && !rsp_chan.reply_abort, rsp_chan.reply_byte == csr_ff.address[7:0], "answer must end on the address low byte")
   `DQFAR_ASSERT_NEXT(a_answer_start, pop_valid && pop_ready && pop_cmd.kind == CMD_ANSWER, !pop_ready, "queue popped during an answer burst")

endmodule

/* sim/tb_dns_query_fixed_answer_responder.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_dns_query_fixed_answer_responder
// self-checking bench for the fixed-answer dns responder: query bytes are
// streamed in from a queue, every accepted byte is run through a local
// parser that builds the reply bytes it should cause, and the reply channel
// is checked byte by byte against them, in most phases under random stalls on both sides
// ---------------------------------------------------------------------------
module tb_dns_query_fixed_answer_responder;
   import dqfar_pkg::*;

   localparam int MAX_BYTES = DEF_MAX_PACKET_BYTES;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } query_item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       abort;
   } reply_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;

   dqfar_req_if req_chan ();
   dqfar_rsp_if rsp_chan ();

   dns_query_fixed_answer_responder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // pending query bytes and reply bytes still owed by the block
   query_item_type query_q[$];
   reply_item_type expected_reply_q[$];

   // local copy of the parser state and registers
   logic [9:0]  byte_pos;
   phase_type   parse_phase;
   logic [2:0]  tails_seen;
   logic [31:0] cfg_address;
   logic [31:0] cfg_ttl;

   int mismatch_count = 0;
   int reply_count    = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   bit idle_enable    = 1'b1;

   // ------------------------------------------------------------------------
   // reply prediction
   // ------------------------------------------------------------------------
   function automatic void restart_parse();
      byte_pos    = '0;
      parse_phase = PH_HEADER;
      tails_seen  = '0;
   endfunction

   function automatic void owe_reply(input logic [7:0] b, input logic l, input logic a);
      reply_item_type r;
      r.data  = b;
      r.last  = l;
      r.abort = a;
      expected_reply_q.push_back(r);
   endfunction

   function automatic void predict_reply(input logic [7:0] b, input logic last);
      logic [7:0]              out_byte;
      logic                    done;
      logic [8*ANSWER_LEN-1:0] answer;
      out_byte = b;
      done     = 1'b0;

      // rest of a datagram after the question or after an oversize abort
      if (parse_phase == PH_SKIP) begin
         if (last) restart_parse();
         return;
      end

      // oversize before the question is complete
      if (int'(byte_pos) >= MAX_BYTES) begin
         owe_reply(ZERO_BYTE, 1'b1, 1'b1);
         restart_parse();
         if (!last) parse_phase = PH_SKIP;
         return;
      end

      case (parse_phase)
         PH_HEADER: begin
            if (byte_pos == HDR_FLAGS_HI_POS) out_byte = FLAGS_HI;
            else if (byte_pos == HDR_FLAGS_LO_POS) out_byte = FLAGS_LO;
            else if (byte_pos == HDR_ANCOUNT_HI_POS) out_byte = ZERO_BYTE;
            else if (byte_pos == HDR_ANCOUNT_LO_POS) out_byte = ANCOUNT_LO;
            else if (byte_pos >= HDR_NSCOUNT_HI_POS && byte_pos <= HDR_ARCOUNT_LO_POS)
               out_byte = ZERO_BYTE;
            if (byte_pos >= HDR_ARCOUNT_LO_POS) parse_phase = PH_NAME;
         end
         PH_NAME: begin
            if (b == ZERO_BYTE) begin
               parse_phase = PH_TAIL;
               tails_seen  = '0;
            end
         end
         default: begin
            if (tails_seen >= TAIL_BYTES - 1) done = 1'b1;
            else tails_seen = tails_seen + 3'd1;
         end
      endcase
      byte_pos = byte_pos + 10'd1;

      if (!done) begin
         // early end drops the copy of this byte
         if (last) begin
            owe_reply(ZERO_BYTE, 1'b1, 1'b1);
            restart_parse();
         end else begin
            owe_reply(out_byte, 1'b0, 1'b0);
         end
         return;
      end

      // question complete: copy the byte, then the fixed a record
      owe_reply(out_byte, 1'b0, 1'b0);
      answer = {PTR_HI, PTR_LO, TYPE_A, CLASS_IN, cfg_ttl, RDLENGTH, cfg_address};
      for (int k = ANSWER_LEN - 1; k >= 0; k--)
         owe_reply(answer[8*k +: 8], k == 0, 1'b0);
      restart_parse();
      if (!last) parse_phase = PH_SKIP;
   endfunction

   // ------------------------------------------------------------------------
   // reply checking
   // ------------------------------------------------------------------------
   function automatic void check_reply(input reply_item_type got);
      reply_item_type want;
      reply_count++;
      if (expected_reply_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("reply %0d unexpected: byte %02h last %0b abort %0b",
                     reply_count, got.data, got.last, got.abort);
         return;
      end
      want = expected_reply_q.pop_front();
      if (got.data !== want.data || got.last !== want.last || got.abort !== want.abort) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("reply %0d: expected byte %02h last %0b abort %0b, got byte %02h last %0b abort %0b",
                     reply_count, want.data, want.last, want.abort,
                     got.data, got.last, got.abort);
      end
   endfunction

   // ------------------------------------------------------------------------
   // query driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid      <= 1'b0;
         req_chan.query_byte <= '0;
         req_chan.query_last <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_reply(query_q[0].data, query_q[0].last);
            void'(query_q.pop_front());
            if (idle_enable && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 7);
         end
         // channel free after this edge: idle or present the next item
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (query_q.size() > 0) begin
               req_chan.valid      <= 1'b1;
               req_chan.query_byte <= query_q[0].data;
               req_chan.query_last <= query_q[0].last;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // reply monitor with random back-pressure
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            check_reply({rsp_chan.reply_byte, rsp_chan.reply_last, rsp_chan.reply_abort});
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_packet(input logic [7:0] bytes[$]);
      query_item_type q;
      for (int k = 0; k < bytes.size(); k++) begin
         q.data = bytes[k];
         q.last = (k == bytes.size() - 1);
         query_q.push_back(q);
      end
   endtask

   task automatic write_register(input logic idx, input logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_ADDRESS) cfg_address = value;
      else cfg_ttl = value;
   endtask

   // block idle: nothing to send, nothing owed
   task automatic wait_until_idle();
      while (query_q.size() != 0 || req_chan.valid || expected_reply_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // header, zero to three labels, root, type and class
   task automatic make_query(output logic [7:0] bytes[$]);
      int labels;
      int len;
      bytes = {};
      repeat (12) bytes.push_back(8'($urandom_range(0, 255)));
      labels = $urandom_range(0, 3);
      repeat (labels) begin
         len = $urandom_range(1, 15);
         bytes.push_back(8'(len));
         repeat (len) bytes.push_back(8'($urandom_range(1, 255)));
      end
      bytes.push_back(ZERO_BYTE);
      repeat (TAIL_BYTES) bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // one random datagram; returns the number of bytes that take part in parsing
   task automatic random_packet(output int counted);
      logic [7:0] bytes[$];
      int         kind;
      int         cut;
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
         make_query(bytes);
         counted = bytes.size();
         // some datagrams carry bytes after the question
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) bytes.push_back(8'($urandom_range(0, 255)));
      end else if (kind <= 7) begin
         // early end anywhere before the question completes
         make_query(bytes);
         cut = $urandom_range(1, bytes.size() - 1);
         while (bytes.size() > cut) void'(bytes.pop_back());
         counted = bytes.size();
      end else begin
         bytes = {};
         repeat ($urandom_range(1, 24)) bytes.push_back(8'($urandom_range(0, 255)));
         counted = bytes.size();
      end
      queue_packet(bytes);
   endtask

   task automatic random_phase(input int target);
      int total;
      int counted;
      total = 0;
      while (total < target) begin
         random_packet(counted);
         total += counted;
      end
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      req_chan.valid      = 1'b0;
      req_chan.query_byte = '0;
      req_chan.query_last = 1'b0;
      rsp_chan.ready      = 1'b0;
      csr_we              = 1'b0;
      csr_index           = CSR_ADDRESS;
      csr_wdata           = '0;
      cfg_address         = '0;
      cfg_ttl             = TTL_RESET;
      restart_parse();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // minimal query with reset registers, rewritten fields all ones but the low flags byte,
      // then two bytes after the question
      queue_packet('{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'h00});
      // early end on the first byte and inside the header
      queue_packet('{8'hFF});
      queue_packet('{8'h00, 8'hFF, 8'h81});
      wait_until_idle();

      // all-ones registers
      write_register(CSR_ADDRESS, 32'hFFFF_FFFF);
      write_register(CSR_TTL, 32'hFFFF_FFFF);
      random_phase(30);
      wait_until_idle();

      // all-zero registers
      write_register(CSR_ADDRESS, 32'h0000_0000);
      write_register(CSR_TTL, 32'h0000_0000);
      random_phase(30);
      wait_until_idle();

      // random registers
      write_register(CSR_ADDRESS, $urandom);
      write_register(CSR_TTL, $urandom);
      random_phase(30);
      wait_until_idle();

      // last stretch runs at full rate on both sides
      write_register(CSR_TTL, $urandom);
      write_register(CSR_ADDRESS, $urandom);
      idle_enable = 1'b0;
      random_phase(30);
      wait_until_idle();
      repeat (40) @(posedge clock);

      if (expected_reply_q.size() != 0) begin
         mismatch_count += expected_reply_q.size();
         $display("%0d expected reply bytes never arrived", expected_reply_q.size());
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(20_000_000);
      $display("Mismatches found");
      $finish;
   end

endmodule
